### hdl/lbsc_pkg.sv
// Shared constants, types and codes for the letterbox nearest-neighbor coordinate mapper.
// No dependencies; every other file of the block takes its names from here.
`default_nettype none
package lbsc_pkg;

    // Canvas edge length in pixels and largest source dimension honored.
    localparam int CANVAS_SIZE    = 240;
    localparam int MAX_SOURCE_DIM = 4096;

    // Port field widths.
    localparam int CFG_W       = 13;   // src_width / src_height registers
    localparam int CRD_W       = 8;    // canvas_x / canvas_y
    localparam int SRC_W       = 12;   // source_x / source_y
    localparam int IDX_W       = 24;   // source_index
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;
    localparam int REG_IDX_W   = 1;

    // Internal widths.
    localparam int DIM_W = $clog2(MAX_SOURCE_DIM + 1);          // clamped dimension
    localparam int FIT_W = $clog2(CANVAS_SIZE);                 // fitted size, offset
    localparam int CAN_W = $clog2(CANVAS_SIZE + 1);             // canvas size itself
    localparam int CMP_W = ((CRD_W > CAN_W) ? CRD_W : CAN_W) + 1;
    localparam int NUM_W = $clog2((CANVAS_SIZE - 1) * MAX_SOURCE_DIM); // d*w + fit/2
    localparam int RK    = NUM_W;                               // reciprocal scale 2^RK
    localparam int RCP_W = RK + 1;
    localparam int FDV_W = $clog2(MAX_SOURCE_DIM * (2 * CANVAS_SIZE - 1) + 1);
    localparam int DV_W  = (FDV_W > RCP_W) ? FDV_W : RCP_W;     // divider dividend
    localparam int DS_W  = DIM_W + 1;                           // divider divisor

    // Pipeline depth: five per-axis stages plus the index / output stage.
    localparam int AX_STG = 5;
    localparam int NSTG   = AX_STG + 1;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

    // Setup sequencer states.
    typedef enum logic [2:0] {
        FC_START,
        FC_FIT_W,
        FC_FIT_H,
        FC_RCP_W,
        FC_RCP_H,
        FC_READY
    } fc_state_t;

    // Per-axis mapping constants derived from the configuration.
    typedef struct packed {
        logic [DIM_W-1:0] side;   // clamped source dimension
        logic [FIT_W-1:0] fit;    // fitted size on the canvas
        logic [FIT_W-1:0] off;    // border width before the fitted area
        logic [RCP_W-1:0] rcp;    // floor(2^RK / fit)
    } axis_cfg_t;

    typedef struct packed {
        logic      ready;
        axis_cfg_t x;
        axis_cfg_t y;
    } map_cfg_t;

endpackage
`default_nettype wire

### hdl/lbsc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, used by the setup sequencer.
// Depends on lbsc_pkg for the operand widths.
`default_nettype none
module lbsc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic                       abort,
    input  wire logic [lbsc_pkg::DV_W-1:0]  dividend,
    input  wire logic [lbsc_pkg::DS_W-1:0]  divisor,
    output logic                            done,
    output logic [lbsc_pkg::DV_W-1:0]       quotient
);

    localparam int DV_W  = lbsc_pkg::DV_W;
    localparam int DS_W  = lbsc_pkg::DS_W;
    localparam int CNT_W = $clog2(DV_W);

    logic [DS_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]  quo_reg, quo_next;
    logic [DS_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DS_W:0]    trial;
    logic [DS_W:0]    diff;
    logic             ge;

    always_comb begin
        trial = {rem_reg, quo_reg[DV_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (abort) begin
            busy_next = 1'b0;
        end else if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DS_W-1:0] : trial[DS_W-1:0];
            quo_next = {quo_reg[DV_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### hdl/lbsc_fit_calc.sv
// Configuration registers and setup sequencer: fitted sizes, offsets and reciprocals.
// Depends on lbsc_pkg and lbsc_div.
`default_nettype none
module lbsc_fit_calc (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [lbsc_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [lbsc_pkg::CFG_W-1:0]      cfg_wdata,
    output lbsc_pkg::map_cfg_t                   map_cfg
);

    localparam int CFG_W = lbsc_pkg::CFG_W;
    localparam int DIM_W = lbsc_pkg::DIM_W;
    localparam int FIT_W = lbsc_pkg::FIT_W;
    localparam int CAN_W = lbsc_pkg::CAN_W;
    localparam int RCP_W = lbsc_pkg::RCP_W;
    localparam int DV_W  = lbsc_pkg::DV_W;
    localparam int DS_W  = lbsc_pkg::DS_W;
    localparam logic [DV_W-1:0] RCP_ONE = DV_W'(1) << lbsc_pkg::RK;

    lbsc_pkg::fc_state_t state_reg, state_next;
    logic             issued_reg, issued_next;
    logic [CFG_W-1:0] srcw_reg, srcw_next;
    logic [CFG_W-1:0] srch_reg, srch_next;
    logic [DIM_W-1:0] w_reg, w_next;
    logic [DIM_W-1:0] h_reg, h_next;
    logic [DIM_W-1:0] m_reg, m_next;
    logic [FIT_W-1:0] nw_reg, nw_next;
    logic [FIT_W-1:0] nh_reg, nh_next;
    logic [FIT_W-1:0] offw_reg, offw_next;
    logic [FIT_W-1:0] offh_reg, offh_next;
    logic [RCP_W-1:0] rcpw_reg, rcpw_next;
    logic [RCP_W-1:0] rcph_reg, rcph_next;

    logic             div_start;
    logic             div_done;
    logic [DV_W-1:0]  div_dvd;
    logic [DS_W-1:0]  div_dvs;
    logic [DV_W-1:0]  div_quo;
    logic [DIM_W-1:0] wc, hc;
    logic [FIT_W-1:0] fitq;
    logic [FIT_W-1:0] fitoff;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] raw);
        logic [DIM_W-1:0] d;
        if (raw == '0) begin
            d = DIM_W'(1);
        end else if (raw > CFG_W'(lbsc_pkg::MAX_SOURCE_DIM)) begin
            d = DIM_W'(lbsc_pkg::MAX_SOURCE_DIM);
        end else begin
            d = DIM_W'(raw);
        end
        return d;
    endfunction

    lbsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .abort    (cfg_we),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // fit = max(1, quotient); offset = (canvas - fit) / 2
    always_comb begin
        fitq   = (div_quo == '0) ? FIT_W'(1) : div_quo[FIT_W-1:0];
        fitoff = FIT_W'((CAN_W'(lbsc_pkg::CANVAS_SIZE) - CAN_W'(fitq)) >> 1);
        wc     = clamp_dim(srcw_reg);
        hc     = clamp_dim(srch_reg);
    end

    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        srcw_next   = srcw_reg;
        srch_next   = srch_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        m_next      = m_reg;
        nw_next     = nw_reg;
        nh_next     = nh_reg;
        offw_next   = offw_reg;
        offh_next   = offh_reg;
        rcpw_next   = rcpw_reg;
        rcph_next   = rcph_reg;
        div_start   = 1'b0;
        div_dvd     = '0;
        div_dvs     = '0;

        case (state_reg)
            lbsc_pkg::FC_START: begin
                w_next     = wc;
                h_next     = hc;
                m_next     = (wc > hc) ? wc : hc;
                state_next = lbsc_pkg::FC_FIT_W;
            end
            lbsc_pkg::FC_FIT_W: begin
                // (2*w*(canvas-1) + m) / (2*m): round half up
                div_dvd = DV_W'(w_reg) * DV_W'(2 * (lbsc_pkg::CANVAS_SIZE - 1))
                          + DV_W'(m_reg);
                div_dvs = {m_reg, 1'b0};
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    nw_next     = fitq;
                    offw_next   = fitoff;
                    issued_next = 1'b0;
                    state_next  = lbsc_pkg::FC_FIT_H;
                end
            end
            lbsc_pkg::FC_FIT_H: begin
                div_dvd = DV_W'(h_reg) * DV_W'(2 * (lbsc_pkg::CANVAS_SIZE - 1))
                          + DV_W'(m_reg);
                div_dvs = {m_reg, 1'b0};
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    nh_next     = fitq;
                    offh_next   = fitoff;
                    issued_next = 1'b0;
                    state_next  = lbsc_pkg::FC_RCP_W;
                end
            end
            lbsc_pkg::FC_RCP_W: begin
                div_dvd = RCP_ONE;
                div_dvs = DS_W'(nw_reg);
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    rcpw_next   = div_quo[RCP_W-1:0];
                    issued_next = 1'b0;
                    state_next  = lbsc_pkg::FC_RCP_H;
                end
            end
            lbsc_pkg::FC_RCP_H: begin
                div_dvd = RCP_ONE;
                div_dvs = DS_W'(nh_reg);
                if (!issued_reg) begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (div_done) begin
                    rcph_next   = div_quo[RCP_W-1:0];
                    issued_next = 1'b0;
                    state_next  = lbsc_pkg::FC_READY;
                end
            end
            lbsc_pkg::FC_READY: begin
                state_next = lbsc_pkg::FC_READY;
            end
            default: begin
                state_next  = lbsc_pkg::FC_START;
                issued_next = 1'b0;
            end
        endcase

        // Any write restarts the setup from the top.
        if (cfg_we) begin
            if (cfg_index == lbsc_pkg::REG_SRC_WIDTH) begin
                srcw_next = cfg_wdata;
            end
            if (cfg_index == lbsc_pkg::REG_SRC_HEIGHT) begin
                srch_next = cfg_wdata;
            end
            state_next  = lbsc_pkg::FC_START;
            issued_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lbsc_pkg::FC_START;
            issued_reg <= 1'b0;
            srcw_reg   <= CFG_W'(240);
            srch_reg   <= CFG_W'(240);
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            srcw_reg   <= srcw_next;
            srch_reg   <= srch_next;
        end
        w_reg    <= w_next;
        h_reg    <= h_next;
        m_reg    <= m_next;
        nw_reg   <= nw_next;
        nh_reg   <= nh_next;
        offw_reg <= offw_next;
        offh_reg <= offh_next;
        rcpw_reg <= rcpw_next;
        rcph_reg <= rcph_next;
    end

    always_comb begin
        map_cfg.ready  = (state_reg == lbsc_pkg::FC_READY);
        map_cfg.x.side = w_reg;
        map_cfg.x.fit  = nw_reg;
        map_cfg.x.off  = offw_reg;
        map_cfg.x.rcp  = rcpw_reg;
        map_cfg.y.side = h_reg;
        map_cfg.y.fit  = nh_reg;
        map_cfg.y.off  = offh_reg;
        map_cfg.y.rcp  = rcph_reg;
    end

endmodule
`default_nettype wire

### hdl/lbsc_axis_pipe.sv
// Five-stage per-axis mapper: border test, numerator, reciprocal multiply,
// remainder check, rounding correction and clamp. Depends on lbsc_pkg.
`default_nettype none
module lbsc_axis_pipe (
    input  wire logic                           aclk,
    input  wire logic [lbsc_pkg::AX_STG-1:0]    en,
    input  wire logic [lbsc_pkg::CRD_W-1:0]     coord,
    input  wire lbsc_pkg::axis_cfg_t            acfg,
    output logic                                in_area,
    output logic [lbsc_pkg::DIM_W-1:0]          src
);

    localparam int DIM_W = lbsc_pkg::DIM_W;
    localparam int FIT_W = lbsc_pkg::FIT_W;
    localparam int CMP_W = lbsc_pkg::CMP_W;
    localparam int NUM_W = lbsc_pkg::NUM_W;
    localparam int RCP_W = lbsc_pkg::RCP_W;
    localparam int RK    = lbsc_pkg::RK;

    logic             ins1_reg, ins1_next;
    logic [FIT_W-1:0] d1_reg, d1_next;
    logic             ins2_reg;
    logic [NUM_W-1:0] n2_reg, n2_next;
    logic             ins3_reg;
    logic [NUM_W-1:0] n3_reg;
    logic [DIM_W-1:0] q3_reg, q3_next;
    logic             ins4_reg;
    logic [NUM_W-1:0] r4_reg, r4_next;
    logic [DIM_W-1:0] q4_reg;
    logic             ins5_reg;
    logic [DIM_W-1:0] s5_reg, s5_next;

    logic [CMP_W-1:0]         c_ext;
    logic [DIM_W+FIT_W-1:0]   dw_prod;
    logic [NUM_W+RCP_W-1:0]   rcp_prod;
    logic [DIM_W+FIT_W-1:0]   back_prod;
    logic [DIM_W-1:0]         q_inc;
    logic [DIM_W-1:0]         side_m1;

    always_comb begin
        // stage 1: inside the fitted span, offset removed
        c_ext     = CMP_W'(coord);
        ins1_next = (c_ext >= CMP_W'(acfg.off)) &&
                    (c_ext < (CMP_W'(acfg.off) + CMP_W'(acfg.fit)));
        d1_next   = FIT_W'(coord - CMP_W'(acfg.off));

        // stage 2: d*side + fit/2
        dw_prod = d1_reg * acfg.side;
        n2_next = dw_prod[NUM_W-1:0] + NUM_W'(acfg.fit >> 1);

        // stage 3: estimate, low by at most one
        rcp_prod = n2_reg * acfg.rcp;
        q3_next  = rcp_prod[RK +: DIM_W];

        // stage 4: remainder of the estimate
        back_prod = q3_reg * acfg.fit;
        r4_next   = n3_reg - back_prod[NUM_W-1:0];

        // stage 5: correct and clamp to side-1
        q_inc   = (r4_reg >= NUM_W'(acfg.fit)) ? (q4_reg + DIM_W'(1)) : q4_reg;
        side_m1 = acfg.side - DIM_W'(1);
        s5_next = (q_inc > side_m1) ? side_m1 : q_inc;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ins1_reg <= ins1_next;
            d1_reg   <= d1_next;
        end
        if (en[1]) begin
            ins2_reg <= ins1_reg;
            n2_reg   <= n2_next;
        end
        if (en[2]) begin
            ins3_reg <= ins2_reg;
            n3_reg   <= n2_reg;
            q3_reg   <= q3_next;
        end
        if (en[3]) begin
            ins4_reg <= ins3_reg;
            r4_reg   <= r4_next;
            q4_reg   <= q3_reg;
        end
        if (en[4]) begin
            ins5_reg <= ins4_reg;
            s5_reg   <= s5_next;
        end
    end

    assign in_area = ins5_reg;
    assign src     = s5_reg;

endmodule
`default_nettype wire

### hdl/letterbox_nearest_scaler_map_top.sv
// Top level of the letterbox nearest-neighbor coordinate mapper.
// Depends on lbsc_pkg, lbsc_fit_calc, lbsc_axis_pipe.
//
// Usage:
//  - s_ channel: one canvas coordinate per transfer, s_tdata = {canvas_y, canvas_x}.
//  - m_ channel: one result per input transfer, in order. m_tuser is the inside
//    flag (0 on the black border); m_tdata = {source_index, source_y, source_x},
//    all zero on the border.
//  - cfg_we / cfg_index / cfg_wdata: write src_width (index 0) or src_height
//    (index 1); values 0 and above 4096 act as 1 and 4096.
//  - Throughput: one transfer per clock once setup is done and while m_tready
//    is high. Every stage has a valid bit and a stall only holds stages that
//    carry data, so bubbles close up. Six register stages (border test,
//    numerator, reciprocal multiply, remainder, correction/clamp, linear
//    index) lie between an input transfer and its result on m_tvalid.
//  - Setup: after reset and after every register write the shared bit-serial
//    divider runs four divisions (two fitted sizes, two reciprocals) in turn,
//    and s_tready stays low until all four are done. Writes are taken
//    at any time and restart the setup.
//  - Stall: with m_tready low the output register holds its result, the stages
//    behind it fill, and s_tready falls once the pipeline is full.
//  - Reset (aresetn low, synchronous) empties the pipeline and loads 240 x 240.
`default_nettype none
module letterbox_nearest_scaler_map_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata: [7:0] canvas_x, [15:8] canvas_y
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lbsc_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: [11:0] source_x, [23:12] source_y, [47:24] source_index
    // m_tuser: [0] inside_res
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lbsc_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [0:0]                              m_tuser,
    input  wire logic                               cfg_we,
    input  wire logic [lbsc_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire logic [lbsc_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int NSTG   = lbsc_pkg::NSTG;
    localparam int AX_STG = lbsc_pkg::AX_STG;
    localparam int CRD_W  = lbsc_pkg::CRD_W;
    localparam int DIM_W  = lbsc_pkg::DIM_W;
    localparam int SRC_W  = lbsc_pkg::SRC_W;
    localparam int IDX_W  = lbsc_pkg::IDX_W;

    lbsc_pkg::map_cfg_t map_cfg;

    logic [NSTG-1:0]  v_reg, v_next;
    logic [NSTG-1:0]  en;

    logic             insx, insy;
    logic [DIM_W-1:0] sx, sy;

    logic             ins6_reg, ins6_next;
    logic [SRC_W-1:0] sx6_reg, sx6_next;
    logic [SRC_W-1:0] sy6_reg, sy6_next;
    logic [IDX_W-1:0] idx6_reg, idx6_next;
    logic [2*DIM_W-1:0] row_prod;
    logic [2*DIM_W-1:0] idx_sum;

    lbsc_fit_calc u_fit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .map_cfg   (map_cfg)
    );

    lbsc_axis_pipe u_axis_x (
        .aclk    (aclk),
        .en      (en[AX_STG-1:0]),
        .coord   (s_tdata[CRD_W-1:0]),
        .acfg    (map_cfg.x),
        .in_area (insx),
        .src     (sx)
    );

    lbsc_axis_pipe u_axis_y (
        .aclk    (aclk),
        .en      (en[AX_STG-1:0]),
        .coord   (s_tdata[2*CRD_W-1:CRD_W]),
        .acfg    (map_cfg.y),
        .in_area (insy),
        .src     (sy)
    );

    // Stage enables: a stage loads when empty or when its successor moves.
    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        s_tready = map_cfg.ready && en[0];

        v_next[0] = en[0] ? (s_tvalid && s_tready) : v_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    // Output stage: linear index, border zeroing.
    always_comb begin
        row_prod  = sy * map_cfg.x.side;
        idx_sum   = row_prod + (2*DIM_W)'(sx);
        ins6_next = insx && insy;
        sx6_next  = ins6_next ? sx[SRC_W-1:0] : '0;
        sy6_next  = ins6_next ? sy[SRC_W-1:0] : '0;
        idx6_next = ins6_next ? idx_sum[IDX_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
        if (en[NSTG-1]) begin
            ins6_reg <= ins6_next;
            sx6_reg  <= sx6_next;
            sy6_reg  <= sy6_next;
            idx6_reg <= idx6_next;
        end
    end

    assign m_tvalid = v_reg[NSTG-1];
    assign m_tdata  = {idx6_reg, sy6_reg, sx6_reg};
    assign m_tuser  = ins6_reg;

endmodule
`default_nettype wire
